// ===== sv/morphing_wavetable_sample_generator_defines.svh =====
// Assertion macros for the morphing wavetable sample generator.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef MORPHING_WAVETABLE_SAMPLE_GENERATOR_DEFINES_SVH
`define MORPHING_WAVETABLE_SAMPLE_GENERATOR_DEFINES_SVH
`ifndef SYNTH
// Condition must never be seen at a clock edge outside reset.
`define MWSG_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("mwsg: forbidden condition seen");
// Antecedent implies consequent in the same cycle.
`define MWSG_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mwsg: implication failed");
// Antecedent implies consequent in the next cycle.
`define MWSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mwsg: next-cycle implication failed");
`else
`define MWSG_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define MWSG_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define MWSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mwsg_pkg.sv =====
// Shared constants, tables and wave functions for the wavetable sample generator.
// No dependencies; imported by the divider and the top level.
`default_nettype none

package mwsg_pkg;

    localparam int CYCLE_LENGTH = 2048;
    localparam int PHASE_W      = 11;
    localparam int HALF_CYCLE   = CYCLE_LENGTH / 2;
    localparam int MIX_STEPS    = 32;
    localparam int MIX_MAX      = MIX_STEPS - 1;
    localparam int CENTER_STEP  = 700;
    localparam int CENTER_SH    = 5;

    localparam int PW_W    = 6;
    localparam int SHAPE_W = 5;
    localparam int WAVE_W  = 2;
    localparam int MIX_W   = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // warp divider: quotient below HALF_CYCLE
    localparam int DIV_Q_W   = PHASE_W - 1;
    localparam int DIV_DEN_W = PHASE_W;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;
    localparam int DIV_BPS   = 2;
    localparam int DIV_STAGES = DIV_Q_W / DIV_BPS;

    localparam int RECIP_SH = 20;
    localparam logic [15:0] MIX_RECIP = 16'((1 << RECIP_SH) / MIX_MAX);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_WIDTH  = 3'd0,
        REG_SHAPE_AMOUNT = 3'd1,
        REG_FIRST_WAVE   = 3'd2,
        REG_SECOND_WAVE  = 3'd3,
        REG_MIX_STEP     = 3'd4
    } t_cfg_reg;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } t_wave;

    localparam logic [15:0] SIN_T [17] = '{
        16'd0, 16'd3212, 16'd6393, 16'd9512, 16'd12540, 16'd15447, 16'd18205,
        16'd20788, 16'd23170, 16'd25330, 16'd27245, 16'd28899, 16'd30274,
        16'd31357, 16'd32138, 16'd32610, 16'd32768
    };
    localparam logic [15:0] LOG_T [17] = '{
        16'd0, 16'd2866, 16'd5568, 16'd8124, 16'd10549, 16'd12855, 16'd15055,
        16'd17156, 16'd19168, 16'd21098, 16'd22952, 16'd24736, 16'd26455,
        16'd28114, 16'd29717, 16'd31267, 16'd32768
    };
    localparam logic [16:0] EXP_T [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    typedef logic [16:0] t_exp_tab [1 << SHAPE_W];

    // Q16 exponent 1.15^-d, rounded after every multiply
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab   tab;
        logic [33:0] e;
        e = 34'd65536;
        for (int d = 0; d < (1 << SHAPE_W); d++) begin
            tab[d] = e[16:0];
            e      = (e * 34'd56988 + 34'd32768) >> 16;
        end
        return tab;
    endfunction

    localparam t_exp_tab SHAPE_EXP = build_exp_tab();

    function automatic logic signed [16:0] quarter_sine(input logic [14:0] r);
        logic [4:0]  k;
        logic [9:0]  fr;
        logic [15:0] diff;
        logic [25:0] prod;
        k  = r[14:10];
        fr = r[9:0];
        if (k[4]) begin
            return 17'sd32768;
        end
        diff = SIN_T[k + 5'd1] - SIN_T[k];
        prod = 26'(diff) * 26'(fr);
        return $signed(17'(SIN_T[k]) + 17'(prod >> 10));
    endfunction

    // p is the Q16 phase fraction, hi marks the second half of the cycle
    function automatic logic signed [16:0] wave_value(input t_wave sel, input logic hi,
                                                      input logic [15:0] p);
        logic [14:0]        r;
        logic signed [16:0] s;
        logic [15:0]        q;
        logic [16:0]        q2;
        logic signed [18:0] t;
        r  = '0;
        s  = '0;
        q  = '0;
        q2 = '0;
        t  = '0;
        unique case (sel)
            WAVE_SINE: begin
                r = {1'b0, p[13:0]};
                if (p[14]) begin
                    r = 15'd16384 - r;
                end
                s = quarter_sine(r);
                return p[15] ? -s : s;
            end
            WAVE_SQUARE: begin
                return hi ? -17'sd32768 : 17'sd32768;
            end
            WAVE_SAW: begin
                return 17'sd32768 - $signed({1'b0, p});
            end
            WAVE_TRIANGLE: begin
                q  = p + 16'd16384;
                q2 = {q, 1'b0};
                t  = q[15] ? 19'sd98304 - $signed({2'b0, q2})
                           : $signed({2'b0, q2}) - 19'sd32768;
                return t[16:0];
            end
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== sv/mwsg_div.sv =====
// Pipelined restoring divider for the phase warp, DIV_BPS quotient bits a stage.
// Depends on mwsg_pkg; stage enables come from the top-level valid chain.
`default_nettype none

module mwsg_div
    import mwsg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [DIV_STAGES-1:0] i_en,
    input  wire logic [DIV_NUM_W-1:0]  i_num,
    input  wire logic [DIV_DEN_W-1:0]  i_den,
    input  wire logic                  i_hi,
    output logic      [DIV_Q_W-1:0]    o_quo,
    output logic                       o_hi
);

    logic [DIV_NUM_W-1:0] r_rem [DIV_STAGES];
    logic [DIV_Q_W-1:0]   r_quo [DIV_STAGES];
    logic [DIV_DEN_W-1:0] r_den [DIV_STAGES];
    logic                 r_hi  [DIV_STAGES];

    logic [DIV_NUM_W-1:0] src_rem [DIV_STAGES];
    logic [DIV_Q_W-1:0]   src_quo [DIV_STAGES];
    logic [DIV_DEN_W-1:0] src_den [DIV_STAGES];
    logic                 src_hi  [DIV_STAGES];

    logic [DIV_NUM_W-1:0] n_rem [DIV_STAGES];
    logic [DIV_Q_W-1:0]   n_quo [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_src
        if (g == 0) begin : g_first
            assign src_rem[g] = i_num;
            assign src_quo[g] = '0;
            assign src_den[g] = i_den;
            assign src_hi[g]  = i_hi;
        end else begin : g_next
            assign src_rem[g] = r_rem[g-1];
            assign src_quo[g] = r_quo[g-1];
            assign src_den[g] = r_den[g-1];
            assign src_hi[g]  = r_hi[g-1];
        end
    end

    always_comb begin
        logic [DIV_NUM_W-1:0] rem;
        logic [DIV_Q_W-1:0]   quo;
        logic [DIV_NUM_W-1:0] trial;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem = src_rem[s];
            quo = src_quo[s];
            for (int j = 0; j < DIV_BPS; j++) begin
                trial = DIV_NUM_W'(src_den[s]) << (DIV_Q_W - 1 - s * DIV_BPS - j);
                if (rem >= trial) begin
                    rem = rem - trial;
                    quo[DIV_Q_W - 1 - s * DIV_BPS - j] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_den[s] <= src_den[s];
                r_hi[s]  <= src_hi[s];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];
    assign o_hi  = r_hi[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/morphing_wavetable_sample_generator.sv =====
// Top level of the morphing wavetable sample generator: config registers,
// stage pipeline and output register. Depends on mwsg_pkg, mwsg_div and the defines header.
//
//  channel   direction  handshake                   payload
//  input     in         i_valid / o_stall           i_phase_index[10:0]
//  output    out        o_valid / i_stall           o_sample[15:0] signed
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index[2:0], i_cfg_data[5:0]
//
// One word enters per cycle while o_stall is low; it passes 15 register stages before
// o_valid rises. The stages are the input stage, the 5-stage warp divider, the wave,
// mix and power-curve stages and the output register.
// Stages collapse bubbles: input is stalled only when every stage holds a word
// and the output is stalled. Reset (synchronous, active low) clears valids and resets config to defaults.
`default_nettype none

`include "morphing_wavetable_sample_generator_defines.svh"

module morphing_wavetable_sample_generator
    import mwsg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PHASE_W-1:0]    i_phase_index,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [15:0]         o_sample,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ST_IN   = 0;
    localparam int ST_DIV0 = 1;
    localparam int ST_WAVE = ST_DIV0 + DIV_STAGES;
    localparam int ST_SUM  = ST_WAVE + 1;
    localparam int ST_RCP  = ST_SUM + 1;
    localparam int ST_CORR = ST_RCP + 1;
    localparam int ST_NORM = ST_CORR + 1;
    localparam int ST_LOG  = ST_NORM + 1;
    localparam int ST_MUL  = ST_LOG + 1;
    localparam int ST_EXP  = ST_MUL + 1;
    localparam int ST_OUT  = ST_EXP + 1;
    localparam int NSTAGE  = ST_OUT + 1;

    // configuration registers
    logic [PW_W-1:0]    r_pulse_width;
    logic [SHAPE_W-1:0] r_shape_amount;
    t_wave              r_first_wave;
    t_wave              r_second_wave;
    logic [MIX_W-1:0]   r_mix_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_width  <= '0;
            r_shape_amount <= '0;
            r_first_wave   <= WAVE_SQUARE;
            r_second_wave  <= WAVE_SINE;
            r_mix_step     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PULSE_WIDTH:  r_pulse_width  <= i_cfg_data[PW_W-1:0];
                REG_SHAPE_AMOUNT: r_shape_amount <= i_cfg_data[SHAPE_W-1:0];
                REG_FIRST_WAVE:   r_first_wave   <= t_wave'(i_cfg_data[WAVE_W-1:0]);
                REG_SECOND_WAVE:  r_second_wave  <= t_wave'(i_cfg_data[WAVE_W-1:0]);
                REG_MIX_STEP:     r_mix_step     <= i_cfg_data[MIX_W-1:0];
                default: ;
            endcase
        end
    end

    // valid chain with bubble collapse
    logic [NSTAGE-1:0] r_valid;
    logic [NSTAGE:0]   w_ready;
    logic [NSTAGE-1:0] n_valid;

    always_comb begin
        w_ready[NSTAGE] = !i_stall;
        for (int i = NSTAGE - 1; i >= 0; i--) begin
            w_ready[i] = !r_valid[i] || w_ready[i+1];
        end
    end

    assign n_valid = {r_valid[NSTAGE-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int i = 0; i < NSTAGE; i++) begin
                if (w_ready[i]) begin
                    r_valid[i] <= n_valid[i];
                end
            end
        end
    end

    assign o_stall = !w_ready[ST_IN];
    assign o_valid = r_valid[ST_OUT];

    // input stage: split point and divider operands
    logic [PW_W-1:0]      pw_sat;
    logic [14:0]          pw_prod;
    logic [PHASE_W-1:0]   center;
    logic                 ph_hi;
    logic [PHASE_W-1:0]   ph_off;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic                 r_hi;

    always_comb begin
        pw_sat  = (r_pulse_width > PW_W'(MIX_STEPS)) ? PW_W'(MIX_STEPS) : r_pulse_width;
        pw_prod = 15'(pw_sat) * 15'(CENTER_STEP);
        center  = PHASE_W'(HALF_CYCLE) + PHASE_W'(pw_prod >> CENTER_SH);
        ph_hi   = i_phase_index >= center;
        ph_off  = ph_hi ? i_phase_index - center : i_phase_index;
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[ST_IN]) begin
            r_num <= DIV_NUM_W'(ph_off) << DIV_Q_W;
            r_den <= ph_hi ? DIV_DEN_W'(12'(CYCLE_LENGTH) - 12'(center)) : center;
            r_hi  <= ph_hi;
        end
    end

    logic [DIV_Q_W-1:0] div_quo;
    logic               div_hi;

    mwsg_div u_div (
        .i_clk (i_clk),
        .i_en  (w_ready[ST_DIV0 +: DIV_STAGES]),
        .i_num (r_num),
        .i_den (r_den),
        .i_hi  (r_hi),
        .o_quo (div_quo),
        .o_hi  (div_hi)
    );

    // wave stage: warped phase to Q16 fraction, both waveforms
    logic [15:0]        phase_frac;
    logic signed [16:0] r_wave_a;
    logic signed [16:0] r_wave_b;

    assign phase_frac = {div_hi, div_quo, {(16 - PHASE_W){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (w_ready[ST_WAVE]) begin
            r_wave_a <= wave_value(r_first_wave, div_hi, phase_frac);
            r_wave_b <= wave_value(r_second_wave, div_hi, phase_frac);
        end
    end

    // morph sum
    logic [MIX_W-1:0]   mix_sat;
    logic [MIX_W-1:0]   coef_a;
    logic signed [22:0] r_sum;

    always_comb begin
        mix_sat = (r_mix_step > MIX_W'(MIX_MAX)) ? MIX_W'(MIX_MAX) : r_mix_step;
        coef_a  = MIX_W'(MIX_MAX) - mix_sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[ST_SUM]) begin
            r_sum <= r_wave_a * $signed({1'b0, coef_a}) + r_wave_b * $signed({1'b0, mix_sat});
        end
    end

    // divide magnitude by MIX_MAX through a reciprocal
    logic [19:0] sum_mag;
    logic [35:0] rcp_prod;
    logic [19:0] r_mag;
    logic [15:0] r_qe;
    logic        r_neg_a;

    always_comb begin
        sum_mag  = r_sum[22] ? 20'(-r_sum) : 20'(r_sum);
        rcp_prod = 36'(sum_mag) * 36'(MIX_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[ST_RCP]) begin
            r_mag   <= sum_mag;
            r_qe    <= 16'(rcp_prod >> RECIP_SH);
            r_neg_a <= r_sum[22];
        end
    end

    // estimate is at most one short
    logic [19:0] qe_back;
    logic [19:0] qe_rem;
    logic [15:0] r_x;
    logic        r_neg_b;

    always_comb begin
        qe_back = 20'(r_qe) * 20'(MIX_MAX);
        qe_rem  = r_mag - qe_back;
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[ST_CORR]) begin
            r_x     <= (qe_rem >= 20'(MIX_MAX)) ? r_qe + 16'd1 : r_qe;
            r_neg_b <= r_neg_a;
        end
    end

    // normalise to 1+f
    logic [3:0]  lead;
    logic [15:0] norm;
    logic        bypass;
    logic [3:0]  r_n;
    logic [14:0] r_f;
    logic        r_bypass_a;
    logic [15:0] r_x_a;
    logic        r_neg_c;

    always_comb begin
        lead = '0;
        for (int i = 0; i < 15; i++) begin
            if (r_x[i]) begin
                lead = 4'(i);
            end
        end
        norm   = r_x << (4'd15 - lead);
        bypass = (r_shape_amount == '0) || (r_x == '0) || r_x[15];
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[ST_NORM]) begin
            r_n        <= lead;
            r_f        <= norm[14:0];
            r_bypass_a <= bypass;
            r_x_a      <= r_x;
            r_neg_c    <= r_neg_b;
        end
    end

    // -log2 of the magnitude, Q15
    logic [3:0]  lg_k;
    logic [10:0] lg_fr;
    logic [15:0] lg_diff;
    logic [26:0] lg_prod;
    logic [15:0] lg_val;
    logic [18:0] r_l;
    logic        r_bypass_b;
    logic [15:0] r_x_b;
    logic        r_neg_d;

    always_comb begin
        lg_k    = r_f[14:11];
        lg_fr   = r_f[10:0];
        lg_diff = LOG_T[5'(lg_k) + 5'd1] - LOG_T[lg_k];
        lg_prod = 27'(lg_diff) * 27'(lg_fr);
        lg_val  = LOG_T[lg_k] + 16'(lg_prod >> 11);
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[ST_LOG]) begin
            r_l        <= 19'({4'd15 - r_n, 15'd0}) - 19'(lg_val);
            r_bypass_b <= r_bypass_a;
            r_x_b      <= r_x_a;
            r_neg_d    <= r_neg_c;
        end
    end

    // scale by the exponent
    logic [35:0] y_prod;
    logic [18:0] r_y;
    logic        r_bypass_c;
    logic [15:0] r_x_c;
    logic        r_neg_e;

    assign y_prod = 36'(r_l) * 36'(SHAPE_EXP[r_shape_amount]);

    always_ff @(posedge i_clk) begin
        if (w_ready[ST_MUL]) begin
            r_y        <= 19'(y_prod >> 16);
            r_bypass_c <= r_bypass_b;
            r_x_c      <= r_x_b;
            r_neg_e    <= r_neg_d;
        end
    end

    // 2^-Y from table, then shift by the integer part
    logic [3:0]  ex_k;
    logic [10:0] ex_fr;
    logic [16:0] ex_diff;
    logic [27:0] ex_prod;
    logic [16:0] ex_val;
    logic [4:0]  ex_sh;
    logic [15:0] r_shaped;
    logic        r_neg_f;

    always_comb begin
        ex_k    = r_y[14:11];
        ex_fr   = r_y[10:0];
        ex_diff = EXP_T[ex_k] - EXP_T[5'(ex_k) + 5'd1];
        ex_prod = 28'(ex_diff) * 28'(ex_fr);
        ex_val  = EXP_T[ex_k] - 17'(ex_prod >> 11);
        ex_sh   = 5'(r_y[18:15]) + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[ST_EXP]) begin
            r_shaped <= r_bypass_c ? r_x_c : 16'(ex_val >> ex_sh);
            r_neg_f  <= r_neg_e;
        end
    end

    // scale by 32767/32768: drop one unless zero, then restore sign
    logic [15:0] out_mag;

    assign out_mag = (r_shaped == '0) ? '0 : r_shaped - 16'd1;

    always_ff @(posedge i_clk) begin
        if (w_ready[ST_OUT]) begin
            o_sample <= r_neg_f ? -$signed(out_mag) : $signed(out_mag);
        end
    end

    `MWSG_ASSERT_NEVER(a_no_min_sample, i_clk, i_rst_n, o_valid && (o_sample == 16'sh8000))
    `MWSG_ASSERT_IMPLIES(a_full_stalls_input, i_clk, i_rst_n, (&r_valid) && i_stall, o_stall)
    `MWSG_ASSERT_IMPLIES(a_mix_in_range, i_clk, i_rst_n, r_valid[ST_CORR], r_x <= 16'd32768)
    `MWSG_ASSERT_NEXT(a_out_loads, i_clk, i_rst_n, r_valid[ST_EXP] && !r_valid[ST_OUT], o_valid)

endmodule

`default_nettype wire
